FILE: design/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("check failed");

// Sequence implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");

`endif

FILE: design/css_pkg.sv
// Types, character codes and color name tables for the CSS color parser.
`default_nettype none

package css_pkg;

	localparam int NAME_LIMIT_DEF   = 63;
	localparam int ALPHA_DIGITS_DEF = 6;
	localparam int NAME_COUNT       = 21;

	typedef enum logic [3:0] {
		PH_LEAD, PH_HEX, PH_WORD, PH_WORD_R, PH_WORD_RG,
		PH_RGB3, PH_RGB4, PH_RGB, PH_RGBA, PH_FAIL
	} phase_t;

	typedef enum logic [3:0] {
		SP_NUM, SP_SIGN, SP_DIGITS, SP_PCT, SP_ALPHA,
		SP_AINT, SP_AFRAC, SP_CLOSE, SP_DONE, SP_FAIL
	} sub_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_UZ     = 8'h5a;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LB     = 8'h62;
	localparam logic [7:0] CH_LF     = 8'h66;
	localparam logic [7:0] CH_LG     = 8'h67;
	localparam logic [7:0] CH_LR     = 8'h72;

	// Names right-justified: last character in bits [7:0].
	localparam logic [87:0] NAME_TEXT [NAME_COUNT] = '{
		88'("black"), 88'("white"), 88'("red"), 88'("green"), 88'("blue"),
		88'("yellow"), 88'("cyan"), 88'("magenta"), 88'("gray"), 88'("grey"),
		88'("silver"), 88'("maroon"), 88'("olive"), 88'("lime"), 88'("aqua"),
		88'("teal"), 88'("navy"), 88'("fuchsia"), 88'("purple"), 88'("orange"),
		88'("transparent")
	};

	localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
		4'd5, 4'd5, 4'd3, 4'd5, 4'd4, 4'd6, 4'd4, 4'd7, 4'd4, 4'd4,
		4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd6, 4'd6, 4'd11
	};

	// {red, green, blue, alpha}
	localparam logic [31:0] NAME_RGBA [NAME_COUNT] = '{
		32'h000000ff, 32'hffffffff, 32'hff0000ff, 32'h008000ff, 32'h0000ffff,
		32'hffff00ff, 32'h00ffffff, 32'hff00ffff, 32'h808080ff, 32'h808080ff,
		32'hc0c0c0ff, 32'h800000ff, 32'h808000ff, 32'h00ff00ff, 32'h00ffffff,
		32'h008080ff, 32'h000080ff, 32'hff00ffff, 32'h800080ff, 32'hffa500ff,
		32'h00000000
	};

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		return is_space(c) || (c == CH_COMMA);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	// floor(x * 255 / 100) for x <= 100, by reciprocal multiply
	function automatic logic [7:0] pct_scale(input logic [6:0] x);
		logic [14:0] y;
		logic [27:0] p;
		begin
			y = 15'(x) * 15'd255;
			p = 28'(y) * 28'd5243;
			return p[26:19];
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/css_color_string_parser.sv
// Top level of the CSS color string parser.
//
// Usage:
//  - Input stream s_axis_*: one ASCII character per item in s_axis_tdata.
//    A NUL character ends the string; every other character produces no
//    output item. Leading whitespace is skipped.
//  - Output stream m_axis_*: exactly one item per NUL. tuser carries the
//    status (0 parsed, 1 invalid), tdata the red, green, blue, alpha bytes.
//  - Throughput: one character per cycle while s_axis_tready is high; the parse
//    state is updated by combinational next-state logic on each accepted character.
//  - Latency: the result for a string is valid in m_axis on the cycle after
//    its NUL is accepted. Alpha division by the fixed fraction scale is a
//    reciprocal multiply on the NUL path into the output register.
//  - Stall: the output register holds its item while m_axis_tready is low;
//    s_axis_tready is high only when that register is empty or is being
//    drained, so a waiting result stalls the input stream.
//  - Reset: all parse state returns to the leading-whitespace phase and the
//    output register empties. The same state is restored after every NUL.
//  - Forms: #rgb, #rrggbb, rgb()/rgba() with integer or percent channels,
//    and 21 case-insensitive color names.
`default_nettype none

module css_color_string_parser import css_pkg::*; #(
	parameter int NAME_LIMIT   = NAME_LIMIT_DEF,
	parameter int ALPHA_DIGITS = ALPHA_DIGITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [31:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
	output      logic        m_axis_tuser    // [0] status
);

	function automatic logic [63:0] pow10(input int n);
		logic [63:0] p;
		begin
			p = 64'd1;
			for (int i = 0; i < n; i++) p = p * 64'd10;
			return p;
		end
	endfunction

	localparam int          PW     = $clog2(NAME_LIMIT + 1);
	localparam int          CW     = $clog2(ALPHA_DIGITS + 1);
	localparam logic [63:0] ASCALE = pow10(ALPHA_DIGITS);
	// fraction is kept pre-multiplied by 255 at scale 10^ALPHA_DIGITS
	localparam int          NF     = $clog2(ASCALE * 64'd255);
	localparam int          SH     = NF + $clog2(ASCALE);
	localparam int          MW     = SH - NF + 9;
	localparam logic [127:0] RECIP = ((128'd1 << SH) + 128'(ASCALE) - 128'd1) / 128'(ASCALE);

	typedef struct packed {
		sub_t             phase;
		logic [1:0]       idx;
		logic [10:0]      acc;
		logic             neg;
		logic [NF-1:0]    frac;
		logic             seen;
		logic             inz;
		logic [CW-1:0]    cnt;
		logic [23:0]      ch;
	} rd_t;

	// digit weight 255 * 10^(ALPHA_DIGITS-1-k)
	function automatic logic [NF-1:0] frac_weight(input logic [CW-1:0] k);
		logic [NF-1:0] w;
		begin
			w = '0;
			for (int i = 0; i < ALPHA_DIGITS; i++)
				if (k == CW'(i)) w = NF'(pow10(ALPHA_DIGITS - 1 - i) * 64'd255);
			return w;
		end
	endfunction

	function automatic rd_t rd_store(input rd_t s, input logic pct, input logic wa);
		rd_t        t;
		logic [7:0] v;
		begin
			t = s;
			if (pct) v = s.neg ? 8'd0 : pct_scale(s.acc > 11'd100 ? 7'd100 : s.acc[6:0]);
			else     v = s.neg ? 8'd0 : (s.acc > 11'd255 ? 8'd255 : s.acc[7:0]);
			unique case (s.idx)
				2'd0:    t.ch[23:16] = v;
				2'd1:    t.ch[15:8]  = v;
				default: t.ch[7:0]   = v;
			endcase
			t.acc = '0;
			t.neg = 1'b0;
			t.idx = s.idx + 2'd1;
			if (s.idx < 2'd2) t.phase = SP_NUM;
			else t.phase = wa ? SP_ALPHA : SP_CLOSE;
			return t;
		end
	endfunction

	function automatic rd_t rd_step(input rd_t s, input logic [7:0] c, input logic pct,
			input logic wa, output logic again);
		rd_t         t;
		logic [3:0]  d;
		logic [14:0] n;
		begin
			t     = s;
			again = 1'b0;
			d     = 4'(c - CH_0);
			n     = 15'(s.acc) * 15'd10 + 15'(d);
			unique case (s.phase)
				SP_NUM: begin
					if (is_sep(c)) t = s;
					else if (c == CH_MINUS) begin
						t.neg = 1'b1; t.phase = SP_SIGN;
					end else if (is_digit(c)) begin
						t.acc = 11'(d); t.phase = SP_DIGITS;
					end else t.phase = SP_FAIL;
				end
				SP_SIGN: begin
					if (is_digit(c)) begin
						t.acc = 11'(d); t.phase = SP_DIGITS;
					end else t.phase = SP_FAIL;
				end
				SP_DIGITS: begin
					if (is_digit(c)) t.acc = (n > 15'd2047) ? 11'd2047 : n[10:0];
					else if (!pct) begin
						t = rd_store(s, pct, wa); again = 1'b1;
					end else begin
						t.phase = SP_PCT; again = 1'b1;
					end
				end
				SP_PCT: begin
					if (is_sep(c)) t = s;
					else if (c == CH_PCT) t = rd_store(s, pct, wa);
					else t.phase = SP_FAIL;
				end
				SP_ALPHA: begin
					if (is_sep(c)) t = s;
					else if (c == CH_PLUS || c == CH_MINUS) begin
						t.neg = (c == CH_MINUS); t.phase = SP_AINT;
					end else if (is_digit(c)) begin
						t.seen = 1'b1; t.inz = s.inz | (d != 4'd0); t.phase = SP_AINT;
					end else if (c == CH_DOT) t.phase = SP_AFRAC;
					else if (c == CH_RPAREN) t.phase = SP_DONE;
					else t.phase = SP_FAIL;
				end
				SP_AINT: begin
					if (is_digit(c)) begin
						t.seen = 1'b1; t.inz = s.inz | (d != 4'd0);
					end else if (c == CH_DOT) t.phase = SP_AFRAC;
					else if (s.seen) begin
						t.phase = SP_CLOSE; again = 1'b1;
					end else t.phase = SP_FAIL;
				end
				SP_AFRAC: begin
					if (is_digit(c)) begin
						t.seen = 1'b1;
						if (s.cnt < CW'(ALPHA_DIGITS)) begin
							t.frac = s.frac + NF'(d) * frac_weight(s.cnt);
							t.cnt  = s.cnt + CW'(1);
						end
					end else if (s.seen) begin
						t.phase = SP_CLOSE; again = 1'b1;
					end else t.phase = SP_FAIL;
				end
				SP_CLOSE: begin
					if (is_sep(c)) t = s;
					else t.phase = (c == CH_RPAREN) ? SP_DONE : SP_FAIL;
				end
				default: t = s;
			endcase
			return t;
		end
	endfunction

	function automatic rd_t rd_feed(input rd_t s, input logic [7:0] c, input logic pct,
			input logic wa);
		rd_t  t;
		logic ag, ag2;
		begin
			t = rd_step(s, c, pct, wa, ag);
			if (ag) t = rd_step(t, c, pct, wa, ag2);
			return t;
		end
	endfunction

	localparam rd_t RD_INIT = '{phase: SP_NUM, default: '0};

	// parse state
	phase_t          phase_q, phase_d;
	logic [PW-1:0]   pos_q, pos_d;
	logic [NAME_COUNT-1:0] match_q, match_d;
	logic [23:0]     hex_q, hex_d;
	logic [2:0]      hcnt_q, hcnt_d;
	logic            pseen_q, pseen_d;
	rd_t             rd_q [2];
	rd_t             rd_d [2];

	// output register
	logic            ovalid_q;
	logic            ostat_q;
	logic [31:0]     orgba_q;

	logic            in_acc, is_nul;
	logic [7:0]      c, lc;
	logic            res_ok;
	logic [31:0]     res_rgba;   // {red, green, blue, alpha}
	logic [3:0]      hv;
	logic            hv_ok;
	logic [3:0]      nofs;
	logic            nfound;
	logic            wa;
	rd_t             rsel;
	logic [NF+MW-1:0] aprod;
	logic [7:0]      abyte;

	assign s_axis_tready = !ovalid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign c             = s_axis_tdata;
	assign is_nul        = (c == CH_NUL);
	assign lc            = (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
	assign wa            = (phase_q == PH_RGBA);

	// hex digit value
	always_comb begin
		hv_ok = 1'b1;
		hv    = 4'd0;
		if (is_digit(c)) hv = 4'(c - CH_0);
		else if (c >= CH_LA && c <= CH_LF) hv = 4'(c - CH_LA + 8'd10);
		else if (c >= CH_UA && c <= CH_UF) hv = 4'(c - CH_UA + 8'd10);
		else hv_ok = 1'b0;
	end

	// next parse state for a non-NUL character
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		match_d = match_q;
		hex_d   = hex_q;
		hcnt_d  = hcnt_q;
		pseen_d = pseen_q;
		rd_d[0] = rd_q[0];
		rd_d[1] = rd_q[1];
		nofs    = 4'd0;
		unique case (phase_q)
			PH_LEAD, PH_WORD, PH_WORD_R, PH_WORD_RG: begin
				if (phase_q == PH_LEAD && is_space(c)) phase_d = PH_LEAD;
				else if (phase_q == PH_LEAD && c == CH_HASH) phase_d = PH_HEX;
				else if (pos_q >= PW'(NAME_LIMIT)) phase_d = PH_FAIL;
				else begin
					for (int j = 0; j < NAME_COUNT; j++) begin
						nofs = 4'(NAME_LEN[j] - 4'd1 - 4'(pos_q));
						if (pos_q >= PW'(NAME_LEN[j])
								|| NAME_TEXT[j][{nofs, 3'b000} +: 8] != lc)
							match_d[j] = 1'b0;
					end
					pos_d = pos_q + PW'(1);
					if (phase_q == PH_LEAD) phase_d = (c == CH_LR) ? PH_WORD_R : PH_WORD;
					else if (phase_q == PH_WORD_R) phase_d = (c == CH_LG) ? PH_WORD_RG : PH_WORD;
					else if (phase_q == PH_WORD_RG) phase_d = (c == CH_LB) ? PH_RGB3 : PH_WORD;
				end
			end
			PH_HEX: begin
				if (!hv_ok || hcnt_q >= 3'd6) phase_d = PH_FAIL;
				else begin
					hex_d  = {hex_q[19:0], hv};
					hcnt_d = hcnt_q + 3'd1;
				end
			end
			PH_RGB3: phase_d = (c == CH_LPAREN) ? PH_RGB : (c == CH_LA) ? PH_RGB4 : PH_FAIL;
			PH_RGB4: phase_d = (c == CH_LPAREN) ? PH_RGBA : PH_FAIL;
			PH_RGB, PH_RGBA: begin
				if (c == CH_PCT) pseen_d = 1'b1;
				rd_d[0] = rd_feed(rd_q[0], c, 1'b0, wa);
				rd_d[1] = rd_feed(rd_q[1], c, 1'b1, wa);
			end
			default: phase_d = phase_q;
		endcase
	end

	// alpha = floor(frac / 10^ALPHA_DIGITS), frac already times 255; 0 if negative or absent, 255 if integer part nonzero
	assign rsel  = pseen_q ? rd_q[1] : rd_q[0];
	assign aprod = (NF+MW)'(rsel.frac) * (NF+MW)'(RECIP);
	assign abyte = (rsel.neg || !rsel.seen) ? 8'd0 : rsel.inz ? 8'd255 : aprod[SH +: 8];

	// result for the string ended by this NUL
	always_comb begin
		res_ok   = 1'b0;
		res_rgba = '0;
		nfound   = 1'b0;
		unique case (phase_q)
			PH_HEX: begin
				if (hcnt_q == 3'd3) begin
					res_ok   = 1'b1;
					res_rgba = {hex_q[11:8], hex_q[11:8], hex_q[7:4], hex_q[7:4],
						hex_q[3:0], hex_q[3:0], 8'hff};
				end else if (hcnt_q == 3'd6) begin
					res_ok   = 1'b1;
					res_rgba = {hex_q, 8'hff};
				end
			end
			PH_WORD, PH_WORD_R, PH_WORD_RG: begin
				for (int j = 0; j < NAME_COUNT; j++)
					if (!nfound && match_q[j] && pos_q == PW'(NAME_LEN[j])) begin
						nfound   = 1'b1;
						res_ok   = 1'b1;
						res_rgba = NAME_RGBA[j];
					end
			end
			PH_RGB, PH_RGBA: begin
				if (rsel.phase == SP_DONE) begin
					res_ok   = 1'b1;
					res_rgba = {rsel.ch, wa ? abyte : 8'hff};
				end
			end
			default: res_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			pos_q    <= '0;
			match_q  <= '1;
			hex_q    <= '0;
			hcnt_q   <= '0;
			pseen_q  <= 1'b0;
			rd_q[0]  <= RD_INIT;
			rd_q[1]  <= RD_INIT;
			ovalid_q <= 1'b0;
		end else begin
			if (in_acc && is_nul) begin
				phase_q  <= PH_LEAD;
				pos_q    <= '0;
				match_q  <= '1;
				hex_q    <= '0;
				hcnt_q   <= '0;
				pseen_q  <= 1'b0;
				rd_q[0]  <= RD_INIT;
				rd_q[1]  <= RD_INIT;
			end else if (in_acc) begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				match_q  <= match_d;
				hex_q    <= hex_d;
				hcnt_q   <= hcnt_d;
				pseen_q  <= pseen_d;
				rd_q[0]  <= rd_d[0];
				rd_q[1]  <= rd_d[1];
			end
			if (in_acc && is_nul) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && is_nul) begin
			ostat_q <= !res_ok;
			orgba_q <= res_rgba;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tuser  = ostat_q;
	assign m_axis_tdata  = {orgba_q[7:0], orgba_q[15:8], orgba_q[23:16], orgba_q[31:24]};

endmodule

`default_nettype wire

FILE: design/css_chk.sv
// Port-level checker for the CSS color parser, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module css_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [7:0]  s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	// a stalled result is held
	`CHK_IMPLY(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
	// a new result only follows an accepted string terminator
	`CHK_IMPLY(a_cause, clk, arst_n, m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready), $past(s_axis_tvalid && s_axis_tready && s_axis_tdata == 8'h00))
	// failures carry all-zero color
	`CHK_IMPLY(a_failzero, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'h0)
	// input is taken whenever the output side is empty
	`CHK_ALWAYS(a_ready, clk, arst_n, m_axis_tvalid || s_axis_tready)

endmodule

bind css_color_string_parser css_chk u_css_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
